### hdl/pzs_pkg.sv
// shared constants, types and angle helpers for the zone shape test
package pzs_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD         = 4;
   localparam int ZW            = ANGLE_BITS + 2;
   localparam int XW            = 32;
   localparam int PIPE_DEPTH    = CORDIC_STAGES + 5;

   localparam logic signed [XW-1:0] INV_GAIN = 32'sd652032874;

   localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
   localparam logic [1:0] SHAPE_BAND   = 2'd1;
   localparam logic [1:0] SHAPE_SECTOR = 2'd2;
   localparam logic [1:0] SHAPE_NONE   = 2'd3;

   localparam logic [2:0] REG_ZONE_SHAPE    = 3'd0;
   localparam logic [2:0] REG_CENTRE_X      = 3'd1;
   localparam logic [2:0] REG_CENTRE_Y      = 3'd2;
   localparam logic [2:0] REG_CIRCLE_RADIUS = 3'd3;
   localparam logic [2:0] REG_AIM_ANGLE     = 3'd4;
   localparam logic [2:0] REG_REACH         = 3'd5;
   localparam logic [2:0] REG_BAND_WIDTH    = 3'd6;
   localparam logic [2:0] REG_HALF_SPREAD   = 3'd7;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cord_type;

   typedef struct packed {
      logic [1:0] shape;
      logic       rot;
      logic       circ_hit;
      logic       dist_ok;
      logic       at_origin;
   } side_type;

   function automatic logic signed [ZW-1:0] atan_step(input int i);
      logic [31:0] t;
      begin
         case (i % 24)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            default: t = 32'h00000051;
         endcase
         t = t >> (32 - ANGLE_BITS);
         return {2'b00, t[ANGLE_BITS-1:0]};
      end
   endfunction

   // 16-bit register angle to internal angle width
   function automatic logic [ANGLE_BITS-1:0] reg_ang(input logic [15:0] a);
      logic [39:0] t;
      begin
         t = {24'd0, a};
         if (ANGLE_BITS >= 16) begin
            t = t << ((ANGLE_BITS >= 16) ? (ANGLE_BITS - 16) : 0);
         end else begin
            t = t >> ((ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0);
         end
         return t[ANGLE_BITS-1:0];
      end
   endfunction

endpackage

### hdl/point_in_zone_shape_test.sv
// top level: point test against a configured circle, band or sector zone
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    point_x, point_y
//  rsp      out        rsp_tvalid/tready    inside_res
//  csr      in         csr_valid/ready      csr_index, csr_data
//
// one item per cycle unless rsp_tready stalls; stages a, b, the cordic chain, d and e
// synchronous active-high reset clears the valid bits and the csr registers to zero
// each stage holds while the one after it is full and stalled; bubbles close up
// csr_ready is always high; the radius and reach squares are registered after a write
module point_in_zone_shape_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // point_x [23:0], point_y [47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // inside_res [0], zero [7:1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import pzs_pkg::*;

   localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);
   localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (ANGLE_BITS - 1);

   logic [1:0]  shape_ff;
   logic [23:0] cx_ff, cy_ff;
   logic [22:0] radius_ff, reach_ff, bw_ff;
   logic [15:0] aim_ff, spread_ff;
   logic [45:0] circ_sq_ff, reach_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= SHAPE_CIRCLE;
         cx_ff     <= '0;
         cy_ff     <= '0;
         radius_ff <= '0;
         aim_ff    <= '0;
         reach_ff  <= '0;
         bw_ff     <= '0;
         spread_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ZONE_SHAPE:    shape_ff  <= csr_data[1:0];
            REG_CENTRE_X:      cx_ff     <= csr_data;
            REG_CENTRE_Y:      cy_ff     <= csr_data;
            REG_CIRCLE_RADIUS: radius_ff <= csr_data[22:0];
            REG_AIM_ANGLE:     aim_ff    <= csr_data[15:0];
            REG_REACH:         reach_ff  <= csr_data[22:0];
            REG_BAND_WIDTH:    bw_ff     <= csr_data[22:0];
            REG_HALF_SPREAD:   spread_ff <= csr_data[15:0];
            default: ;
         endcase
      end
      circ_sq_ff  <= radius_ff * radius_ff;
      reach_sq_ff <= reach_ff * reach_ff;
   end

   // stall chain
   logic en_a, en_b, en_d, en_e, cord_ready, cord_valid;
   logic va_ff, vb_ff, vd_ff, ve_ff;

   assign en_e       = !ve_ff || rsp_tready;
   assign en_d       = !vd_ff || en_e;
   assign en_b       = !vb_ff || cord_ready;
   assign en_a       = !va_ff || en_b;
   assign req_tready = en_a;

   // stage a: offsets
   logic signed [24:0] dx_ff, dy_ff, dx_in, dy_in;

   assign dx_in = {req_tdata[23], req_tdata[23:0]} - {cx_ff[23], cx_ff};
   assign dy_in = {req_tdata[47], req_tdata[47:24]} - {cy_ff[23], cy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_a) begin
         va_ff <= req_tvalid;
      end
      if (en_a) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // stage b: squares and cordic start vector
   logic signed [49:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic               origin_ff;
   cord_type           init_ff, init_in;
   logic signed [XW-1:0] xg, yg;
   logic [ANGLE_BITS-1:0] zr;
   logic signed [ZW-1:0]  zrw;
   logic                  is_band;

   assign sqx_in  = dx_ff * dx_ff;
   assign sqy_in  = dy_ff * dy_ff;
   assign is_band = (shape_ff == SHAPE_BAND);

   always_comb begin
      xg  = {{(XW-25-GUARD){dx_ff[24]}}, dx_ff, {GUARD{1'b0}}};
      yg  = {{(XW-25-GUARD){dy_ff[24]}}, dy_ff, {GUARD{1'b0}}};
      zr  = -reg_ang(aim_ff);
      zrw = {{2{zr[ANGLE_BITS-1]}}, zr};
      init_in.x = xg;
      init_in.y = yg;
      init_in.z = '0;
      if (is_band) begin
         init_in.z = zrw;
         if (zrw > QUARTER || zrw < -QUARTER) begin
            init_in.x = -xg;
            init_in.y = -yg;
            init_in.z = zrw[ZW-1] ? zrw + HALF : zrw - HALF;
         end
      end else if (dx_ff[24]) begin
         init_in.x = -xg;
         init_in.y = -yg;
         init_in.z = HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en_b) begin
         vb_ff <= va_ff;
      end
      if (en_b) begin
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         origin_ff <= (dx_ff == '0) && (dy_ff == '0);
         init_ff   <= init_in;
      end
   end

   // distance tests at the cordic entry
   logic [50:0] d2;
   side_type    side_in, side_out;
   cord_type    cord_out;

   assign d2 = {1'b0, sqx_ff[49:0]} + {1'b0, sqy_ff[49:0]};

   always_comb begin
      side_in.shape     = shape_ff;
      side_in.rot       = is_band;
      side_in.circ_hit  = d2 <= {5'd0, circ_sq_ff};
      side_in.dist_ok   = d2 <= {5'd0, reach_sq_ff};
      side_in.at_origin = origin_ff;
   end

   pzs_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vb_ff),
      .in_ready  (cord_ready),
      .in_cord   (init_ff),
      .in_side   (side_in),
      .out_valid (cord_valid),
      .out_ready (en_d),
      .out_cord  (cord_out),
      .out_side  (side_out)
   );

   // stage d: gain removal products and angle difference
   logic signed [63:0] px_ff, py_ff, px_in, py_in;
   logic [ANGLE_BITS-1:0] diff;
   logic [ANGLE_BITS:0]   absd;
   logic                  ang_ok_ff, ang_ok_in;
   side_type              side_d_ff;

   assign px_in = cord_out.x * INV_GAIN;
   assign py_in = cord_out.y * INV_GAIN;

   always_comb begin
      diff      = cord_out.z[ANGLE_BITS-1:0] - reg_ang(aim_ff);
      absd      = diff[ANGLE_BITS-1] ? ({1'b0, ~diff} + 1'b1) : {1'b0, diff};
      ang_ok_in = absd <= {1'b0, reg_ang(spread_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en_d) begin
         vd_ff <= cord_valid;
      end
      if (en_d) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         ang_ok_ff <= ang_ok_in;
         side_d_ff <= side_out;
      end
   end

   // stage e: final compares into the output register
   logic signed [33:0] along, perp, pabs;
   logic               along_ok, perp_ok, hit_in, hit_ff;

   always_comb begin
      along    = px_ff[63:30];
      perp     = py_ff[63:30];
      pabs     = perp[33] ? -perp : perp;
      along_ok = !along[33] && (along <= {7'd0, reach_ff, {GUARD{1'b0}}});
      perp_ok  = {pabs, 1'b0} <= {8'd0, bw_ff, {GUARD{1'b0}}};
      case (side_d_ff.shape)
         SHAPE_CIRCLE: hit_in = side_d_ff.circ_hit;
         SHAPE_BAND:   hit_in = along_ok && perp_ok;
         SHAPE_SECTOR: hit_in = side_d_ff.dist_ok && (side_d_ff.at_origin || ang_ok_ff);
         default:      hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en_e) begin
         ve_ff <= vd_ff;
      end
      if (en_e) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_tvalid = ve_ff;
   assign rsp_tdata  = {7'd0, hit_ff};

endmodule

### hdl/pzs_cordic.sv
// pipelined cordic, one micro-rotation per g_step stage, shared rotate and vector modes
module pzs_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pzs_pkg::cord_type in_cord,
   input  pzs_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output pzs_pkg::cord_type out_cord,
   output pzs_pkg::side_type out_side
);
   import pzs_pkg::*;

   localparam int N = CORDIC_STAGES;

   logic     valid_ff [N+1];
   cord_type cord_ff  [N+1];
   side_type side_ff  [N+1];
   logic     en       [N+1];

   assign en[N]     = !valid_ff[N] || out_ready;
   assign in_ready  = en[0];
   assign out_valid = valid_ff[N];
   assign out_cord  = cord_ff[N];
   assign out_side  = side_ff[N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (en[0]) begin
         cord_ff[0] <= in_cord;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      cord_type step_in;
      logic     pos;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;

      assign en[k] = !valid_ff[k] || en[k+1];

      always_comb begin
         xs  = cord_ff[k].x >>> k;
         ys  = cord_ff[k].y >>> k;
         pos = side_ff[k].rot ? !cord_ff[k].z[ZW-1] : (cord_ff[k].y <= 0);
         if (pos) begin
            step_in.x = cord_ff[k].x - ys;
            step_in.y = cord_ff[k].y + xs;
            step_in.z = cord_ff[k].z - atan_step(k);
         end else begin
            step_in.x = cord_ff[k].x + ys;
            step_in.y = cord_ff[k].y - xs;
            step_in.z = cord_ff[k].z + atan_step(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en[k+1]) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en[k+1]) begin
            cord_ff[k+1] <= step_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

endmodule

### hdl/pzs_checker.sv
// port-level checks for the zone shape test, bound to the top level
module pzs_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import pzs_pkg::*;

   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_tvalid && req_tready) cnt_in = cnt_in + 6'd1;
      if (rsp_tvalid && rsp_tready) cnt_in = cnt_in - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != 6'd0)
      else $error("result without an item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'(PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

endmodule

bind point_in_zone_shape_test pzs_port_checks u_pzs_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/pzs_checker.sv
// zone test checker: watches the channels, predicts each verdict and compares
`timescale 1ns / 1ps
module pzs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          open_count
);
   import pzs_pkg::*;

   logic [1:0]         cfg_shape;
   logic signed [23:0] cfg_cx, cfg_cy;
   logic [22:0]        cfg_radius, cfg_reach, cfg_width;
   logic [15:0]        cfg_aim, cfg_spread;

   bit verdict_q[$];

   localparam longint FULL_TURN = longint'(1) << ANGLE_BITS;

   function automatic longint wrap_angle(input longint a);
      longint r;
      r = a & (FULL_TURN - 1);
      if (r >= FULL_TURN / 2) r -= FULL_TURN;
      return r;
   endfunction

   function automatic longint widen_angle(input logic [15:0] a);
      if (ANGLE_BITS >= 16) return longint'(a) << ((ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0);
      return longint'(a) >> ((ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0);
   endfunction

   function automatic longint micro_angle(input int i);
      logic [31:0] t;
      case (i % 24)
         0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
         12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
         18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
         21: t = 32'h00000146;  22: t = 32'h000000A3;  default: t = 32'h00000051;
      endcase
      return longint'(t >> (32 - ANGLE_BITS));
   endfunction

   function automatic int stage_total();
      return (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   endfunction

   function automatic bit in_band(input longint dx, input longint dy);
      longint x, y, z, xs, ys, along, perp;
      longint quarter, half;
      x = dx * (1 << GUARD);
      y = dy * (1 << GUARD);
      quarter = FULL_TURN / 4;
      half = FULL_TURN / 2;
      z = wrap_angle(-widen_angle(cfg_aim));
      if (z > quarter || z < -quarter) begin
         x = -x;
         y = -y;
         z = (z < 0) ? z + half : z - half;
      end
      for (int i = 0; i < stage_total(); i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z -= micro_angle(i);
         end else begin
            x = x + ys; y = y - xs; z += micro_angle(i);
         end
      end
      along = (x * longint'(INV_GAIN)) >>> 30;
      perp = (y * longint'(INV_GAIN)) >>> 30;
      if (perp < 0) perp = -perp;
      if (along < 0 || along > (longint'(cfg_reach) << GUARD)) return 0;
      return 2 * perp <= (longint'(cfg_width) << GUARD);
   endfunction

   function automatic longint bearing(input longint dx, input longint dy);
      longint x, y, acc, xs, ys;
      x = dx * (1 << GUARD);
      y = dy * (1 << GUARD);
      acc = 0;
      if (x < 0) begin
         x = -x; y = -y; acc = FULL_TURN / 2;
      end
      for (int i = 0; i < stage_total(); i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; acc += micro_angle(i);
         end else begin
            x = x - ys; y = y + xs; acc -= micro_angle(i);
         end
      end
      return wrap_angle(acc);
   endfunction

   function automatic bit in_sector(input longint dx, input longint dy);
      longint diff;
      if (dx * dx + dy * dy > longint'(cfg_reach) * longint'(cfg_reach)) return 0;
      if (dx == 0 && dy == 0) return 1;
      diff = wrap_angle(bearing(dx, dy) - widen_angle(cfg_aim));
      if (diff < 0) diff = -diff;
      return diff <= widen_angle(cfg_spread);
   endfunction

   function automatic bit zone_verdict(input logic signed [23:0] px,
                                       input logic signed [23:0] py);
      longint dx, dy;
      dx = longint'(px) - longint'(cfg_cx);
      dy = longint'(py) - longint'(cfg_cy);
      case (cfg_shape)
         SHAPE_CIRCLE: return dx * dx + dy * dy <= longint'(cfg_radius) * longint'(cfg_radius);
         SHAPE_BAND:   return in_band(dx, dy);
         SHAPE_SECTOR: return in_sector(dx, dy);
         default:      return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         cfg_shape <= SHAPE_CIRCLE;
         cfg_cx <= '0; cfg_cy <= '0;
         cfg_radius <= '0; cfg_reach <= '0; cfg_width <= '0;
         cfg_aim <= '0; cfg_spread <= '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected item inside_res", -1, rsp_tdata[0]);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want) report_mismatch("inside_res", want, rsp_tdata[0]);
            end
         end
         if (req_tvalid && req_tready)
            verdict_q.push_back(zone_verdict(req_tdata[23:0], req_tdata[47:24]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ZONE_SHAPE:    cfg_shape <= csr_data[1:0];
               REG_CENTRE_X:      cfg_cx <= csr_data;
               REG_CENTRE_Y:      cfg_cy <= csr_data;
               REG_CIRCLE_RADIUS: cfg_radius <= csr_data[22:0];
               REG_AIM_ANGLE:     cfg_aim <= csr_data[15:0];
               REG_REACH:         cfg_reach <= csr_data[22:0];
               REG_BAND_WIDTH:    cfg_width <= csr_data[22:0];
               REG_HALF_SPREAD:   cfg_spread <= csr_data[15:0];
               default:           ;
            endcase
         end
      end
      open_count = verdict_q.size();
   end

endmodule

### tb/sv/tb_top.sv
// zone test testbench top: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
   import pzs_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 0;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;
   int          fail_count, open_count;
   int          quiet_cycles;
   bit          calm;
   bit          hold_go;
   int          hold_left;

   point_in_zone_shape_test dut (.*);

   pzs_checker checker_i (.*);

   always #5 clock = ~clock;

   initial begin
      reset = 1;
      req_tvalid = 0; req_tdata = '0;
      rsp_tready = 0;
      csr_valid = 0; csr_index = REG_ZONE_SHAPE; csr_data = '0;
      calm = 0; hold_go = 0; hold_left = 0;
   end

   // receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go = 0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 29);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_point(input logic [23:0] px, input logic [23:0] py);
      while (!calm && $urandom_range(99) < 29) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic set_zone(input logic [1:0] shape, input logic [23:0] cx,
                           input logic [23:0] cy, input logic [23:0] rad,
                           input logic [15:0] aim, input logic [23:0] rch,
                           input logic [23:0] bw, input logic [15:0] hs);
      settle();
      write_reg(REG_ZONE_SHAPE, {22'd0, shape});
      write_reg(REG_CENTRE_X, cx);
      write_reg(REG_CENTRE_Y, cy);
      write_reg(REG_CIRCLE_RADIUS, rad);
      write_reg(REG_AIM_ANGLE, {8'd0, aim});
      write_reg(REG_REACH, rch);
      write_reg(REG_BAND_WIDTH, bw);
      write_reg(REG_HALF_SPREAD, {8'd0, hs});
   endtask

   initial begin
      logic [1:0]  shape;
      logic [23:0] cx, cy, rad, rch, bw, span, ox, oy;
      logic [15:0] aim, hs;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // reset settings: zero radius circle at the origin
      push_point(24'd0, 24'd0);
      push_point(24'd1, 24'd0);
      set_zone(SHAPE_CIRCLE, 24'd0, 24'd0, 24'd256, 16'd0, 24'd0, 24'd0, 16'd0);
      push_point(24'd256, 24'd0);
      push_point(24'd256, 24'd1);
      push_point(-24'sd256, 24'd0);
      set_zone(SHAPE_CIRCLE, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'd0, 24'd0, 24'd0, 16'd0);
      push_point(24'h7FFFFF, 24'h800000);
      push_point(24'h800000, 24'h7FFFFF);
      set_zone(SHAPE_BAND, 24'd0, 24'd0, 24'd0, 16'd0, 24'd1024, 24'd512, 16'd0);
      push_point(24'd0, 24'd0);
      push_point(24'd1024, 24'd0);
      push_point(24'd1040, 24'd0);
      push_point(-24'sd16, 24'd0);
      push_point(24'd500, 24'd256);
      push_point(24'd500, 24'd270);
      set_zone(SHAPE_BAND, 24'd0, 24'd0, 24'd0, 16'd49152, 24'h7FFFFF, 24'h7FFFFF, 16'd0);
      push_point(24'd0, -24'sd4096);
      push_point(24'h7FFFFF, 24'h800000);
      set_zone(SHAPE_SECTOR, 24'd0, 24'd0, 24'd0, 16'd0, 24'd1024, 24'd0, 16'd8192);
      push_point(24'd0, 24'd0);
      push_point(24'd1024, 24'd0);
      push_point(24'd512, 24'd512);
      push_point(24'd0, 24'd700);
      set_zone(SHAPE_SECTOR, 24'd0, 24'd0, 24'd0, 16'd32768, 24'h7FFFFF, 24'd0, 16'd32768);
      push_point(-24'sd500, 24'd0);
      push_point(24'd500, 24'd3);
      set_zone(SHAPE_NONE, 24'd0, 24'd0, 24'h7FFFFF, 16'd0, 24'h7FFFFF, 24'h7FFFFF, 16'd32768);
      push_point(24'd0, 24'd0);

      for (int phase = 0; phase < 12; phase++) begin
         shape = (phase == 11) ? SHAPE_NONE : 2'(phase % 3);
         cx = (phase % 4 == 3) ? 24'($urandom) : 24'($signed($urandom_range(8191)) - 4096);
         cy = (phase % 4 == 3) ? 24'($urandom) : 24'($signed($urandom_range(8191)) - 4096);
         rad = (phase == 9) ? 24'h7FFFFF : {12'd0, 12'($urandom)};
         rch = (phase == 10) ? 24'h7FFFFF : {12'd0, 12'($urandom)};
         bw = {13'd0, 11'($urandom)};
         aim = (phase < 4) ? 16'(phase * 16384) : 16'($urandom);
         hs = (phase == 5) ? 16'd0 : (phase == 8) ? 16'd32768 : 16'($urandom_range(32768));
         set_zone(shape, cx, cy, rad, aim, rch, bw, hs);
         calm = (phase == 6);
         if (phase == 4) hold_go = 1;
         span = ((shape == SHAPE_CIRCLE) ? rad : rch) + 24'd64;
         for (int k = 0; k < 50; k++) begin
            if ($urandom_range(99) < 20) begin
               push_point(24'($urandom), 24'($urandom));
            end else begin
               ox = 24'($signed({1'b0, span}) - $signed({1'b0, 24'($urandom % (2 * span + 1))}));
               oy = 24'($signed({1'b0, span}) - $signed({1'b0, 24'($urandom % (2 * span + 1))}));
               push_point(cx + ox, cy + oy);
            end
         end
         calm = 0;
      end

      req_tvalid <= 0;
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
